// ===== design/ddsnow_pkg.sv =====
// shared types and constants of the degree-day snow cell update pipeline
package ddsnow_pkg;

    // field widths
    localparam int TEMP_W     = 15;
    localparam int Q16_W      = 16;
    localparam int FRESH_W    = 17;
    localparam int SWE_W      = 32;
    localparam int STEP_W     = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // pipeline depth, output register included
    localparam int NUM_STAGES = 7;

    // fixed-point constants
    localparam logic [FRESH_W-1:0] ONE_Q16     = 17'd65536;
    localparam logic [Q16_W-1:0]   ALBEDO_RAIN = 16'd26214;
    localparam logic [Q16_W-1:0]   ALBEDO_SNOW = 16'd52429;

    // albedo 0.4*(1+f) rounded: (4*f + 4*65536 + 5) / 10
    localparam logic [19:0] ALB_OFFSET     = 20'd262149;
    // ceil(2^23 / 10), exact division by ten for operands below 2^22
    localparam logic [19:0] RECIP_TEN      = 20'd838861;
    localparam int          RECIP_TEN_SHIFT = 23;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SNOW_TEMP_LOW   = 3'd0,
        REG_SNOW_TEMP_HIGH  = 3'd1,
        REG_SNOW_SPAN_RECIP = 3'd2,
        REG_MELT_TEMP_LOW   = 3'd3,
        REG_MELT_SPAN_RECIP = 3'd4,
        REG_MELT_COEFF      = 3'd5,
        REG_DECAY_PER_STEP  = 3'd6,
        REG_STEP_FACTOR     = 3'd7
    } cfg_reg_t;

    // register file contents as seen by the datapath
    typedef struct packed {
        logic signed [TEMP_W-1:0] snow_temp_low;
        logic signed [TEMP_W-1:0] snow_temp_high;
        logic [Q16_W-1:0]         snow_span_recip;
        logic signed [TEMP_W-1:0] melt_temp_low;
        logic [Q16_W-1:0]         melt_span_recip;
        logic [Q16_W-1:0]         melt_coeff;
        logic [FRESH_W-1:0]       decay;          // clamped to one
        logic [STEP_W-1:0]        step_factor;
    } cfg_t;

endpackage

// ===== design/ddsnow_cfg.sv =====
// configuration register file of the snow cell update
module ddsnow_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [ddsnow_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ddsnow_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output ddsnow_pkg::cfg_t                 cfg
);
    import ddsnow_pkg::*;

    logic signed [TEMP_W-1:0] snow_temp_low_reg;
    logic signed [TEMP_W-1:0] snow_temp_high_reg;
    logic [Q16_W-1:0]         snow_span_recip_reg;
    logic signed [TEMP_W-1:0] melt_temp_low_reg;
    logic [Q16_W-1:0]         melt_span_recip_reg;
    logic [Q16_W-1:0]         melt_coeff_reg;
    logic [FRESH_W-1:0]       decay_per_step_reg;
    logic [STEP_W-1:0]        step_factor_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snow_temp_low_reg   <= 15'sd0;
            snow_temp_high_reg  <= 15'sd512;
            snow_span_recip_reg <= 16'd128;
            melt_temp_low_reg   <= 15'sd0;
            melt_span_recip_reg <= 16'd128;
            melt_coeff_reg      <= 16'd1024;
            decay_per_step_reg  <= 17'd60000;
            step_factor_reg     <= 13'd256;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SNOW_TEMP_LOW:   snow_temp_low_reg   <= $signed(cfg_wdata[TEMP_W-1:0]);
                REG_SNOW_TEMP_HIGH:  snow_temp_high_reg  <= $signed(cfg_wdata[TEMP_W-1:0]);
                REG_SNOW_SPAN_RECIP: snow_span_recip_reg <= cfg_wdata[Q16_W-1:0];
                REG_MELT_TEMP_LOW:   melt_temp_low_reg   <= $signed(cfg_wdata[TEMP_W-1:0]);
                REG_MELT_SPAN_RECIP: melt_span_recip_reg <= cfg_wdata[Q16_W-1:0];
                REG_MELT_COEFF:      melt_coeff_reg      <= cfg_wdata[Q16_W-1:0];
                REG_DECAY_PER_STEP:  decay_per_step_reg  <= cfg_wdata[FRESH_W-1:0];
                REG_STEP_FACTOR:     step_factor_reg     <= cfg_wdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // datapath view, decay limited to one
    always_comb begin
        cfg.snow_temp_low   = snow_temp_low_reg;
        cfg.snow_temp_high  = snow_temp_high_reg;
        cfg.snow_span_recip = snow_span_recip_reg;
        cfg.melt_temp_low   = melt_temp_low_reg;
        cfg.melt_span_recip = melt_span_recip_reg;
        cfg.melt_coeff      = melt_coeff_reg;
        cfg.decay           = (decay_per_step_reg > ONE_Q16) ? ONE_Q16 : decay_per_step_reg;
        cfg.step_factor     = step_factor_reg;
    end

endmodule

// ===== design/degree_day_snow_cell_update.sv =====
// degree-day snow cell update: seven-stage pipeline with configuration registers
//
//   port group  direction  handshake         contents
//   s_*         in         s_valid/s_ready   cell record for one time step
//   m_*         out        m_valid/m_ready   updated swe, freshness, albedo
//   cfg_*       in         cfg_we            register index and write data
//
// one cell record per cycle sustained while m_ready stays high; the pipeline depth from input
// transfer to result is set by the chain of five multiplies in the melt term
// synchronous active-low reset clears all stage valid bits and loads register defaults
// each stage holds while the next one is full and stalled; bubbles are squeezed out,
// so with m_ready low the pipe still takes up to seven items before s_ready drops
module degree_day_snow_cell_update (
    input  logic                               aclk,
    input  logic                               aresetn,
    // cell record in
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [ddsnow_pkg::TEMP_W-1:0] s_air_temp,
    input  logic [ddsnow_pkg::Q16_W-1:0]       s_precipitation,
    input  logic [ddsnow_pkg::Q16_W-1:0]       s_cell_area,
    input  logic [ddsnow_pkg::Q16_W-1:0]       s_radiation_index,
    input  logic [ddsnow_pkg::SWE_W-1:0]       s_swe_in,
    input  logic [ddsnow_pkg::FRESH_W-1:0]     s_freshness_in,
    input  logic [ddsnow_pkg::Q16_W-1:0]       s_albedo_in,
    // updated record out
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [ddsnow_pkg::SWE_W-1:0]       m_swe_out,
    output logic [ddsnow_pkg::FRESH_W-1:0]     m_freshness_out,
    output logic [ddsnow_pkg::Q16_W-1:0]       m_albedo_out,
    // configuration writes
    input  logic                               cfg_we,
    input  logic [ddsnow_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ddsnow_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import ddsnow_pkg::*;

    // stage payloads
    typedef struct packed {
        logic [SWE_W-1:0]      pa;       // precipitation * area
        logic signed [32:0]    p_snow;   // (T - snow_low) * snow recip
        logic signed [32:0]    p_melt;   // (T - melt_low) * melt recip
        logic [SWE_W-1:0]      m1;       // melt_coeff * radiation
        logic [FRESH_W-1:0]    fresh;
        logic                  rain;
        logic                  melt_on;
        logic                  wet;
        logic [SWE_W-1:0]      swe;
        logic [Q16_W-1:0]      albedo;
        logic [Q16_W-1:0]      area;
    } st1_t;

    typedef struct packed {
        logic [SWE_W-1:0]      pa;
        logic [FRESH_W-1:0]    frac;
        logic [FRESH_W-1:0]    ramp;
        logic [39:0]           alb_prod;
        logic [FRESH_W-1:0]    fresh_dec;
        logic [SWE_W-1:0]      m1;
        logic                  rain;
        logic                  melt_on;
        logic                  wet;
        logic [SWE_W-1:0]      swe;
        logic [Q16_W-1:0]      albedo;
        logic [Q16_W-1:0]      area;
    } st2_t;

    typedef struct packed {
        logic [32:0]           add;
        logic [Q16_W-1:0]      alb_f;
        logic [SWE_W-1:0]      m2;
        logic [FRESH_W-1:0]    ramp;
        logic [FRESH_W-1:0]    fresh_dec;
        logic                  rain;
        logic                  melt_on;
        logic                  wet;
        logic [SWE_W-1:0]      swe;
        logic [Q16_W-1:0]      albedo;
        logic [Q16_W-1:0]      area;
    } st3_t;

    typedef struct packed {
        logic [SWE_W-1:0]      swe_sum;
        logic [36:0]           m3;
        logic [FRESH_W-1:0]    ramp;
        logic [Q16_W-1:0]      alb_f;
        logic [Q16_W-1:0]      albedo_sel;
        logic [FRESH_W-1:0]    fresh_dec;
        logic                  melt_on;
        logic [Q16_W-1:0]      area;
    } st4_t;

    typedef struct packed {
        logic [SWE_W-1:0]      swe_sum;
        logic                  swe_nz;
        logic [37:0]           m4;
        logic [Q16_W-1:0]      alb_f;
        logic [Q16_W-1:0]      albedo_sel;
        logic [FRESH_W-1:0]    fresh_dec;
        logic                  melt_on;
        logic [Q16_W-1:0]      area;
    } st5_t;

    typedef struct packed {
        logic [SWE_W-1:0]      swe_sum;
        logic                  swe_nz;
        logic [39:0]           m5;
        logic [Q16_W-1:0]      alb_f;
        logic [Q16_W-1:0]      albedo_sel;
        logic [FRESH_W-1:0]    fresh_dec;
        logic                  melt_on;
    } st6_t;

    typedef struct packed {
        logic [SWE_W-1:0]      swe;
        logic [FRESH_W-1:0]    fresh;
        logic [Q16_W-1:0]      albedo;
    } st7_t;

    cfg_t cfg;

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] stage_en;

    st1_t st1_reg, st1_next;
    st2_t st2_reg, st2_next;
    st3_t st3_reg, st3_next;
    st4_t st4_reg, st4_next;
    st5_t st5_reg, st5_next;
    st6_t st6_reg, st6_next;
    st7_t st7_reg, st7_next;

    // stage 1 intermediates
    logic signed [15:0] d_snow;
    logic signed [15:0] d_melt;
    // stage 2 intermediates
    logic signed [33:0] snow_val;
    logic [19:0]        alb_num;
    logic [33:0]        fresh_prod;
    // stage 3 intermediates
    logic [48:0]        add_prod;
    logic [Q16_W-1:0]   alb_f;
    logic [FRESH_W-1:0] one_minus_alb;
    logic [48:0]        m2_prod;
    // stage 4 intermediates
    logic [33:0]        swe_wide;
    logic [44:0]        m3_prod;
    // stage 5 / 6 intermediates
    logic [53:0]        m4_prod;
    logic [53:0]        m5_prod;

    ddsnow_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // stage enables: a stage loads when empty or when its contents move on
    always_comb begin
        stage_en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !vld_reg[k] || stage_en[k+1];
        end
        vld_next[0] = s_valid;
        for (int k = 1; k < NUM_STAGES; k++) begin
            vld_next[k] = vld_reg[k-1];
        end
    end

    assign s_ready = stage_en[0];
    assign m_valid = vld_reg[NUM_STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                if (stage_en[k]) begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    // stage 1: temperature offsets, threshold flags, first products
    always_comb begin
        d_snow = 16'(s_air_temp) - 16'(cfg.snow_temp_low);
        d_melt = 16'(s_air_temp) - 16'(cfg.melt_temp_low);
        st1_next.p_snow  = d_snow * $signed({1'b0, cfg.snow_span_recip});
        st1_next.p_melt  = d_melt * $signed({1'b0, cfg.melt_span_recip});
        st1_next.pa      = s_precipitation * s_cell_area;
        st1_next.m1      = cfg.melt_coeff * s_radiation_index;
        st1_next.wet     = (s_precipitation != '0);
        st1_next.rain    = (s_air_temp > cfg.snow_temp_high);
        st1_next.melt_on = (s_air_temp > cfg.melt_temp_low);
        if (st1_next.wet || s_freshness_in > ONE_Q16) begin
            st1_next.fresh = ONE_Q16;
        end else begin
            st1_next.fresh = s_freshness_in;
        end
        st1_next.swe     = s_swe_in;
        st1_next.albedo  = s_albedo_in;
        st1_next.area    = s_cell_area;
    end

    // stage 2: clamp snow fraction and melt ramp, albedo numerator times 1/10, decay
    always_comb begin
        snow_val = 34'sd65536 - 34'(st1_reg.p_snow);
        if (snow_val < 0) begin
            st2_next.frac = '0;
        end else if (snow_val > 34'sd65536) begin
            st2_next.frac = ONE_Q16;
        end else begin
            st2_next.frac = snow_val[FRESH_W-1:0];
        end
        if (st1_reg.p_melt < 0) begin
            st2_next.ramp = '0;
        end else if (st1_reg.p_melt > 33'sd65536) begin
            st2_next.ramp = ONE_Q16;
        end else begin
            st2_next.ramp = st1_reg.p_melt[FRESH_W-1:0];
        end
        alb_num             = ALB_OFFSET + {1'b0, st1_reg.fresh, 2'b00};
        st2_next.alb_prod   = alb_num * RECIP_TEN;
        fresh_prod          = st1_reg.fresh * cfg.decay;
        st2_next.fresh_dec  = fresh_prod[32:16];
        st2_next.pa         = st1_reg.pa;
        st2_next.m1         = st1_reg.m1;
        st2_next.rain       = st1_reg.rain;
        st2_next.melt_on    = st1_reg.melt_on;
        st2_next.wet        = st1_reg.wet;
        st2_next.swe        = st1_reg.swe;
        st2_next.albedo     = st1_reg.albedo;
        st2_next.area       = st1_reg.area;
    end

    // stage 3: added snow, freshness albedo, melt times (1 - albedo)
    always_comb begin
        add_prod           = st2_reg.pa * st2_reg.frac;
        st3_next.add       = add_prod[48:16];
        alb_f              = st2_reg.alb_prod[RECIP_TEN_SHIFT+Q16_W-1:RECIP_TEN_SHIFT];
        st3_next.alb_f     = alb_f;
        one_minus_alb      = ONE_Q16 - {1'b0, alb_f};
        m2_prod            = st2_reg.m1 * one_minus_alb;
        st3_next.m2        = m2_prod[47:16];
        st3_next.ramp      = st2_reg.ramp;
        st3_next.fresh_dec = st2_reg.fresh_dec;
        st3_next.rain      = st2_reg.rain;
        st3_next.melt_on   = st2_reg.melt_on;
        st3_next.wet       = st2_reg.wet;
        st3_next.swe       = st2_reg.swe;
        st3_next.albedo    = st2_reg.albedo;
        st3_next.area      = st2_reg.area;
    end

    // stage 4: saturating snow accumulation, precipitation albedo select, melt times step factor
    always_comb begin
        swe_wide = {2'b00, st3_reg.swe} + {1'b0, st3_reg.add};
        if (st3_reg.wet && !st3_reg.rain) begin
            st4_next.swe_sum = (swe_wide[33:32] != 2'b00) ? '1 : swe_wide[SWE_W-1:0];
        end else begin
            st4_next.swe_sum = st3_reg.swe;
        end
        if (!st3_reg.wet) begin
            st4_next.albedo_sel = st3_reg.albedo;
        end else if (st3_reg.rain) begin
            st4_next.albedo_sel = ALBEDO_RAIN;
        end else begin
            st4_next.albedo_sel = ALBEDO_SNOW;
        end
        m3_prod            = st3_reg.m2 * cfg.step_factor;
        st4_next.m3        = m3_prod[44:8];
        st4_next.ramp      = st3_reg.ramp;
        st4_next.alb_f     = st3_reg.alb_f;
        st4_next.fresh_dec = st3_reg.fresh_dec;
        st4_next.melt_on   = st3_reg.melt_on;
        st4_next.area      = st3_reg.area;
    end

    // stage 5: melt times ramp
    always_comb begin
        m4_prod             = st4_reg.m3 * st4_reg.ramp;
        st5_next.m4         = m4_prod[53:16];
        st5_next.swe_sum    = st4_reg.swe_sum;
        st5_next.swe_nz     = (st4_reg.swe_sum != '0);
        st5_next.alb_f      = st4_reg.alb_f;
        st5_next.albedo_sel = st4_reg.albedo_sel;
        st5_next.fresh_dec  = st4_reg.fresh_dec;
        st5_next.melt_on    = st4_reg.melt_on;
        st5_next.area       = st4_reg.area;
    end

    // stage 6: melt times area
    always_comb begin
        m5_prod             = st5_reg.m4 * st5_reg.area;
        st6_next.m5         = m5_prod[53:14];
        st6_next.swe_sum    = st5_reg.swe_sum;
        st6_next.swe_nz     = st5_reg.swe_nz;
        st6_next.alb_f      = st5_reg.alb_f;
        st6_next.albedo_sel = st5_reg.albedo_sel;
        st6_next.fresh_dec  = st5_reg.fresh_dec;
        st6_next.melt_on    = st5_reg.melt_on;
    end

    // stage 7: floored melt subtraction and final albedo select
    always_comb begin
        if (st6_reg.swe_nz && st6_reg.melt_on) begin
            if (st6_reg.m5 >= {8'd0, st6_reg.swe_sum}) begin
                st7_next.swe = '0;
            end else begin
                st7_next.swe = st6_reg.swe_sum - st6_reg.m5[SWE_W-1:0];
            end
        end else begin
            st7_next.swe = st6_reg.swe_sum;
        end
        st7_next.albedo = st6_reg.swe_nz ? st6_reg.alb_f : st6_reg.albedo_sel;
        st7_next.fresh  = st6_reg.fresh_dec;
    end

    // stage payload registers
    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            st1_reg <= st1_next;
        end
        if (stage_en[1]) begin
            st2_reg <= st2_next;
        end
        if (stage_en[2]) begin
            st3_reg <= st3_next;
        end
        if (stage_en[3]) begin
            st4_reg <= st4_next;
        end
        if (stage_en[4]) begin
            st5_reg <= st5_next;
        end
        if (stage_en[5]) begin
            st6_reg <= st6_next;
        end
        if (stage_en[6]) begin
            st7_reg <= st7_next;
        end
    end

    assign m_swe_out       = st7_reg.swe;
    assign m_freshness_out = st7_reg.fresh;
    assign m_albedo_out    = st7_reg.albedo;

    // input side only blocks when the first stage holds an item that cannot move
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> vld_reg[0])
        else $error("input stalled with empty first stage");

    // an item in stage one moves to stage two when stage two is free
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[0] && stage_en[1]) |=> vld_reg[1])
        else $error("item lost between first and second stage");

    // decayed freshness never exceeds one
    a_fresh_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_freshness_out <= ONE_Q16))
        else $error("freshness above one");

    // with snow left, albedo comes from freshness and lies between 0.4 and 0.8
    a_albedo_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_swe_out != '0) |->
            (m_albedo_out >= ALBEDO_RAIN && m_albedo_out <= ALBEDO_SNOW))
        else $error("snow albedo out of range");

endmodule

// ===== tb/sv/tb_degree_day_snow_cell_update.sv =====
// testbench for the degree-day snow cell update: directed table, random cell records, scoreboard
module tb_degree_day_snow_cell_update;
    timeunit 1ns;
    timeprecision 1ps;

    import ddsnow_pkg::*;

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 235;
    localparam int NUM_ROWS        = 19;
    localparam int QUIET_LIMIT     = 2000;
    localparam int HOLD_CYCLES     = 48;
    localparam int IDLE_PCT        = 12;
    localparam int REPORT_MAX      = 10;

    // one cell record and one updated record
    typedef struct packed {
        logic signed [TEMP_W-1:0] air_temp;
        logic [Q16_W-1:0]         precip;
        logic [Q16_W-1:0]         area;
        logic [Q16_W-1:0]         rad;
        logic [SWE_W-1:0]         swe;
        logic [FRESH_W-1:0]       fresh;
        logic [Q16_W-1:0]         albedo;
    } cell_t;

    typedef struct packed {
        logic [SWE_W-1:0]   swe;
        logic [FRESH_W-1:0] fresh;
        logic [Q16_W-1:0]   albedo;
    } record_t;

    // directed row: typed-in result used only when fixed is set
    typedef struct packed {
        cell_t   rec;
        logic    fixed;
        record_t want;
    } row_t;

    // raw write data for all eight registers
    typedef struct packed {
        logic [CFG_DATA_W-1:0] snow_lo;
        logic [CFG_DATA_W-1:0] snow_hi;
        logic [CFG_DATA_W-1:0] snow_recip;
        logic [CFG_DATA_W-1:0] melt_lo;
        logic [CFG_DATA_W-1:0] melt_recip;
        logic [CFG_DATA_W-1:0] coeff;
        logic [CFG_DATA_W-1:0] decay;
        logic [CFG_DATA_W-1:0] step;
    } reg_image_t;

    // register values as the predictor sees them
    typedef struct {
        logic signed [TEMP_W-1:0] snow_lo;
        logic signed [TEMP_W-1:0] snow_hi;
        logic [Q16_W-1:0]         snow_recip;
        logic signed [TEMP_W-1:0] melt_lo;
        logic [Q16_W-1:0]         melt_recip;
        logic [Q16_W-1:0]         coeff;
        logic [FRESH_W-1:0]       decay;
        logic [STEP_W-1:0]        step;
    } cell_params_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [TEMP_W-1:0] s_air_temp;
    logic [Q16_W-1:0]         s_precipitation;
    logic [Q16_W-1:0]         s_cell_area;
    logic [Q16_W-1:0]         s_radiation_index;
    logic [SWE_W-1:0]         s_swe_in;
    logic [FRESH_W-1:0]       s_freshness_in;
    logic [Q16_W-1:0]         s_albedo_in;
    logic                     m_valid;
    logic                     m_ready;
    logic [SWE_W-1:0]         m_swe_out;
    logic [FRESH_W-1:0]       m_freshness_out;
    logic [Q16_W-1:0]         m_albedo_out;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_wdata;

    cell_params_t params;
    record_t      due_records[$];
    int           mismatches;
    int           quiet_cycles;
    bit           steady;
    bit           hold_req;

    degree_day_snow_cell_update i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_air_temp        (s_air_temp),
        .s_precipitation   (s_precipitation),
        .s_cell_area       (s_cell_area),
        .s_radiation_index (s_radiation_index),
        .s_swe_in          (s_swe_in),
        .s_freshness_in    (s_freshness_in),
        .s_albedo_in       (s_albedo_in),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_swe_out         (m_swe_out),
        .m_freshness_out   (m_freshness_out),
        .m_albedo_out      (m_albedo_out),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // clamp a signed ramp value into [0, one]
    function automatic longint unsigned clamp_unit(longint v);
        if (v < 0) return 0;
        if (v > longint'(ONE_Q16)) return ONE_Q16;
        return v;
    endfunction

    // updated cell record under the current register values
    function automatic record_t snow_cell_next(cell_t c);
        longint          temp;
        longint          d;
        longint unsigned fresh;
        longint unsigned swe;
        longint unsigned albedo;
        longint unsigned decay;
        longint unsigned frac;
        longint unsigned ramp;
        longint unsigned melt;
        record_t         r;
        temp   = c.air_temp;
        fresh  = (c.fresh > ONE_Q16) ? ONE_Q16 : c.fresh;
        decay  = (params.decay > ONE_Q16) ? ONE_Q16 : params.decay;
        swe    = c.swe;
        albedo = c.albedo;
        // fresh precipitation: rain sets albedo, snow adds water by fraction
        if (c.precip != 0) begin
            fresh = ONE_Q16;
            if (temp > longint'(params.snow_hi)) begin
                albedo = ALBEDO_RAIN;
            end else begin
                d = temp - longint'(params.snow_lo);
                frac = clamp_unit(longint'(ONE_Q16) - d * longint'(params.snow_recip));
                swe = swe + ((longint'(c.precip) * c.area * frac) >> 16);
                if (swe > 64'hFFFF_FFFF) swe = 64'hFFFF_FFFF;
                albedo = ALBEDO_SNOW;
            end
        end
        // snow cover: albedo from freshness, then melt above the threshold
        if (swe != 0) begin
            albedo = (4 * (ONE_Q16 + fresh) + 5) / 10;
            if (temp > longint'(params.melt_lo)) begin
                d = temp - longint'(params.melt_lo);
                ramp = clamp_unit(d * longint'(params.melt_recip));
                melt = longint'(params.coeff) * c.rad;
                melt = (melt * (ONE_Q16 - albedo)) >> 16;
                melt = (melt * params.step) >> 8;
                melt = (melt * ramp) >> 16;
                melt = (melt * c.area) >> 14;
                swe = (melt >= swe) ? 0 : swe - melt;
            end
        end
        fresh = (fresh * decay) >> 16;
        r.swe    = swe[SWE_W-1:0];
        r.fresh  = fresh[FRESH_W-1:0];
        r.albedo = albedo[Q16_W-1:0];
        return r;
    endfunction

    // one register write, also applied to the predictor copy
    task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        case (idx)
            REG_SNOW_TEMP_LOW:   params.snow_lo    = v[TEMP_W-1:0];
            REG_SNOW_TEMP_HIGH:  params.snow_hi    = v[TEMP_W-1:0];
            REG_SNOW_SPAN_RECIP: params.snow_recip = v[Q16_W-1:0];
            REG_MELT_TEMP_LOW:   params.melt_lo    = v[TEMP_W-1:0];
            REG_MELT_SPAN_RECIP: params.melt_recip = v[Q16_W-1:0];
            REG_MELT_COEFF:      params.coeff      = v[Q16_W-1:0];
            REG_DECAY_PER_STEP:  params.decay      = v[FRESH_W-1:0];
            REG_STEP_FACTOR:     params.step       = v[STEP_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // offer one cell record, record the expected update on transfer
    task automatic send_cell(input cell_t c, input record_t want);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid           <= 1'b1;
        s_air_temp        <= c.air_temp;
        s_precipitation   <= c.precip;
        s_cell_area       <= c.area;
        s_radiation_index <= c.rad;
        s_swe_in          <= c.swe;
        s_freshness_in    <= c.fresh;
        s_albedo_in       <= c.albedo;
        do @(posedge aclk); while (!s_ready);
        due_records.push_back(want);
        @(negedge aclk);
    endtask

    // result side: random back-pressure plus one long hold-off
    initial begin : result_sink
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done && hold_left == 0) hold_left = HOLD_CYCLES;
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
                hold_done = 1;
            end else begin
                m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge aclk) begin : result_check
        record_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_records.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: unexpected result swe %h fresh %h albedo %h",
                             $realtime, m_swe_out, m_freshness_out, m_albedo_out);
            end else begin
                want = due_records.pop_front();
                if (want.swe !== m_swe_out || want.fresh !== m_freshness_out ||
                    want.albedo !== m_albedo_out) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("%0t: mismatch, expected swe %h fresh %h albedo %h",
                                 $realtime, want.swe, want.fresh, want.albedo);
                        $display("%0t:           actual   swe %h fresh %h albedo %h",
                                 $realtime, m_swe_out, m_freshness_out, m_albedo_out);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout after %0d cycles without a transfer", quiet_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin : stimulus
        row_t       rows [NUM_ROWS];
        reg_image_t phase_regs [NUM_PHASES];
        cell_t      c;
        int         tval;
        int         sel;

        aresetn           = 1'b0;
        s_valid           = 1'b0;
        s_air_temp        = '0;
        s_precipitation   = '0;
        s_cell_area       = '0;
        s_radiation_index = '0;
        s_swe_in          = '0;
        s_freshness_in    = '0;
        s_albedo_in       = '0;
        cfg_we            = 1'b0;
        cfg_index         = REG_SNOW_TEMP_LOW;
        cfg_wdata         = '0;
        mismatches        = 0;
        quiet_cycles      = 0;
        steady            = 0;
        hold_req          = 0;

        // register values after reset
        params.snow_lo    = 0;
        params.snow_hi    = 512;
        params.snow_recip = 128;
        params.melt_lo    = 0;
        params.melt_recip = 128;
        params.coeff      = 1024;
        params.decay      = 60000;
        params.step       = 256;

        // directed records: air_temp, precip, area, rad, swe, fresh, albedo
        rows = '{
            // all zero, albedo passes through
            '{'{15'sd0, 16'd0, 16'd0, 16'd0, 32'd0, 17'd0, 16'd0},
              1'b1, '{32'd0, 17'd0, 16'd0}},
            // bare freshness decay
            '{'{15'sd0, 16'd0, 16'd0, 16'd0, 32'd0, 17'd65536, 16'd1234},
              1'b1, '{32'd0, 17'd60000, 16'd1234}},
            // freshness above one is taken as one
            '{'{15'sd0, 16'd0, 16'd0, 16'd0, 32'd0, 17'h1FFFF, 16'hFFFF},
              1'b1, '{32'd0, 17'd60000, 16'hFFFF}},
            // rain on bare ground
            '{'{15'sd12800, 16'd1, 16'd0, 16'd0, 32'd0, 17'd0, 16'd0},
              1'b1, '{32'd0, 17'd60000, 16'd26214}},
            // rain just above the snow threshold on snow
            '{'{15'sd513, 16'hFFFF, 16'd100, 16'd16384, 32'h10000, 17'd0, 16'd0},
              1'b0, '0},
            // exactly at the upper snow threshold
            '{'{15'sd512, 16'd256, 16'd10000, 16'd0, 32'd0, 17'd100, 16'd9},
              1'b0, '0},
            // coldest in range, largest snowfall
            '{'{-15'sd12800, 16'hFFFF, 16'hFFFF, 16'd0, 32'd0, 17'd0, 16'd0},
              1'b1, '{32'hFFFE0001, 17'd60000, 16'd52429}},
            // swe saturation
            '{'{-15'sd12800, 16'hFFFF, 16'hFFFF, 16'd0, 32'hFFFFFFFF, 17'd0, 16'd0},
              1'b1, '{32'hFFFFFFFF, 17'd60000, 16'd52429}},
            // partial snow fraction with melt
            '{'{15'sd256, 16'd1000, 16'd400, 16'd20000, 32'd5000, 17'd30000, 16'd500},
              1'b0, '0},
            // exactly at the melt threshold
            '{'{15'sd0, 16'd0, 16'd2000, 16'hFFFF, 32'd1000, 17'd20000, 16'd0},
              1'b0, '0},
            // one step above the melt threshold
            '{'{15'sd1, 16'd0, 16'd2000, 16'hFFFF, 32'd100000, 17'd20000, 16'd0},
              1'b0, '0},
            // melt floors swe at zero
            '{'{15'sd12800, 16'd0, 16'hFFFF, 16'hFFFF, 32'd1, 17'd0, 16'd0},
              1'b1, '{32'd0, 17'd0, 16'd26214}},
            // partial melt of a deep pack
            '{'{15'sd200, 16'd0, 16'd50, 16'd8000, 32'h00FF0000, 17'd40000, 16'd7},
              1'b0, '0},
            // temperature at the 15 bit maximum
            '{'{15'h3FFF, 16'd0, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 17'd65536, 16'h8000},
              1'b0, '0},
            // temperature at the 15 bit minimum
            '{'{15'h4000, 16'hFFFF, 16'hFFFF, 16'h4000, 32'h12345678, 17'd1, 16'd3},
              1'b0, '0},
            // zero area with precipitation
            '{'{15'sd100, 16'hFFFF, 16'd0, 16'd300, 32'd0, 17'd5, 16'd77},
              1'b0, '0},
            // zero radiation, no melt
            '{'{15'sd3000, 16'd0, 16'd900, 16'd0, 32'd777777, 17'd12345, 16'd1},
              1'b0, '0},
            // cold snow pack, albedo from freshness
            '{'{-15'sd300, 16'd0, 16'd10, 16'd10, 32'd4096, 17'd65536, 16'd2},
              1'b0, '0},
            // every field at its top, but air temperature at 12800
            '{'{15'sd12800, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 17'h1FFFF, 16'hFFFF},
              1'b0, '0}
        };

        // register settings per phase; phase 0 keeps the reset values
        phase_regs[0] = '0;
        phase_regs[1] = '{17'(-512), 17'd768, 17'd51, 17'(-256), 17'd64, 17'd768,
                          17'd58000, 17'd1536};
        phase_regs[2] = '{17'(-12800), 17'(-12800), 17'd0, 17'(-12800), 17'd0, 17'd0,
                          17'd0, 17'd0};
        phase_regs[3] = '{17'd12800, 17'd12800, 17'd65535, 17'(-12800), 17'd65535,
                          17'd65535, 17'h1FFFF, 17'd6144};
        phase_regs[4] = '1;
        for (int p = 5; p < NUM_PHASES; p++) begin
            phase_regs[p].snow_lo    = 17'(int'($urandom_range(25600)) - 12800);
            phase_regs[p].snow_hi    = 17'(int'($urandom_range(25600)) - 12800);
            phase_regs[p].snow_recip = 17'($urandom_range(65535));
            phase_regs[p].melt_lo    = 17'(int'($urandom_range(25600)) - 12800);
            phase_regs[p].melt_recip = 17'($urandom_range(65535));
            phase_regs[p].coeff      = 17'($urandom_range(65535));
            phase_regs[p].decay      = ($urandom_range(3) == 0) ? 17'd65536
                                                                : 17'($urandom_range(65536));
            phase_regs[p].step       = 17'($urandom_range(6144));
        end

        // reset
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int p = 0; p < NUM_PHASES; p++) begin
            // reprogram only with the pipe drained
            if (p > 0) begin
                while (due_records.size() != 0) @(negedge aclk);
                repeat (NUM_STAGES) @(negedge aclk);
                cfg_write(REG_SNOW_TEMP_LOW,   phase_regs[p].snow_lo);
                cfg_write(REG_SNOW_TEMP_HIGH,  phase_regs[p].snow_hi);
                cfg_write(REG_SNOW_SPAN_RECIP, phase_regs[p].snow_recip);
                cfg_write(REG_MELT_TEMP_LOW,   phase_regs[p].melt_lo);
                cfg_write(REG_MELT_SPAN_RECIP, phase_regs[p].melt_recip);
                cfg_write(REG_MELT_COEFF,      phase_regs[p].coeff);
                cfg_write(REG_DECAY_PER_STEP,  phase_regs[p].decay);
                cfg_write(REG_STEP_FACTOR,     phase_regs[p].step);
                cfg_we <= 1'b0;
            end

            // directed table under reset values
            if (p == 0) begin
                for (int i = 0; i < NUM_ROWS; i++)
                    send_cell(rows[i].rec, rows[i].fixed ? rows[i].want
                                                         : snow_cell_next(rows[i].rec));
            end

            // phase 1 runs without idling and with the long output hold-off
            steady   = (p == 1);
            hold_req = (p == 1);

            // random cell records, temperatures biased to the thresholds
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                sel = $urandom_range(7);
                case (sel)
                    0, 1:    tval = $urandom;
                    2, 3, 4: tval = int'($urandom_range(25600)) - 12800;
                    5:       tval = int'(params.snow_lo) + int'($urandom_range(600)) - 300;
                    6:       tval = int'(params.snow_hi) + int'($urandom_range(600)) - 300;
                    default: tval = int'(params.melt_lo) + int'($urandom_range(600)) - 300;
                endcase
                c.air_temp = tval[TEMP_W-1:0];
                case ($urandom_range(3))
                    0:       c.precip = '0;
                    1:       c.precip = 16'($urandom_range(255));
                    default: c.precip = 16'($urandom);
                endcase
                c.area = ($urandom_range(3) == 0) ? 16'($urandom_range(16)) : 16'($urandom);
                c.rad  = 16'($urandom);
                case ($urandom_range(3))
                    0:       c.swe = '0;
                    1:       c.swe = 32'($urandom_range(65535));
                    2:       c.swe = $urandom;
                    default: c.swe = 32'hFFFF_0000 | 32'($urandom_range(65535));
                endcase
                c.fresh  = ($urandom_range(7) == 0) ? 17'($urandom)
                                                    : 17'($urandom_range(65536));
                c.albedo = 16'($urandom);
                send_cell(c, snow_cell_next(c));
            end

            // stop offering once the phase is sent
            s_valid <= 1'b0;
        end
        steady = 0;

        // drain and let the pipe settle
        while (due_records.size() != 0) @(posedge aclk);
        repeat (NUM_STAGES + 3) @(posedge aclk);
        if (mismatches == 0 && due_records.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/ddsnow_pkg.sv
design/ddsnow_cfg.sv
design/degree_day_snow_cell_update.sv
tb/sv/tb_degree_day_snow_cell_update.sv
